>>> rtl/buddy_page_allocator_defines.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (r) prop) else $error(msg);
`define BPA_ASSERT_NEXT(lbl, c, r, pre, post, msg) \
  lbl: assert property (@(posedge c) disable iff (r) pre |=> post) else $error(msg);
`else
`define BPA_ASSERT(lbl, c, r, prop, msg)
`define BPA_ASSERT_NEXT(lbl, c, r, pre, post, msg)
`endif
`endif

>>> rtl/bpa_pkg.sv
// Types, codes and defaults shared by the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int POOL_DEPTH_DEF   = 1024;
  localparam int ORDER_LEVELS_DEF = 11;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 36;
  localparam logic [10:0] POOL_PAGES_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME = 1'd1;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_BLK  = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] order;
    logic [9:0] page_index;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  block_index;
    logic [10:0] free_pages;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/buddy_page_allocator.sv
// Buddy page allocator: sequencer around a page memory and per-order free lists.
//
// A request is a transfer on start while busy is low. mode selects init,
// allocate or free. One result transfer follows per request: done is high
// for exactly one cycle with status, block_index and free_pages valid; the
// receiver cannot hold it off, and the next request may start in that cycle.
// The page memory holds order, taken flag and list links for every page. It
// has one read and one write port with registered read data, and every list
// or merge step is a read followed by a write, so the memory port sets the
// latency. A request rejected at once (unused mode, page out of range or no
// block of the order) keeps busy low and answers in the next cycle. A free
// checks that its page is taken, then per merge level reads the buddy, drops
// it from its list and writes the merged block, and ends with a list insert;
// an allocate unlinks the head block and pushes one buddy per split level. An
// init walks every pool page as a free. Reset empties all lists and the pool;
// configuration writes are taken at any cycle and act at the next init.
`default_nettype none
`include "buddy_page_allocator_defines.svh"
module buddy_page_allocator #(
  parameter int POOL_DEPTH   = bpa_pkg::POOL_DEPTH_DEF,
  parameter int ORDER_LEVELS = bpa_pkg::ORDER_LEVELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire bpa_pkg::request_t              request,
  output logic                                done,
  output bpa_pkg::result_t                    result,
  input  wire logic                           cfg_we,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam int OW     = $clog2(ORDER_LEVELS);
  localparam int OL     = ORDER_LEVELS;
  localparam int BW     = ((IDX_W > OL) ? IDX_W : OL) + 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

  typedef struct packed {
    logic              taken;
    logic [OW-1:0]     order;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } page_word_t;

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_INIT     = 17'h00002,
    ST_F_CHK    = 17'h00004,
    ST_A_RD     = 17'h00008,
    ST_REL      = 17'h00010,
    ST_REL_BUD  = 17'h00020,
    ST_MERGE    = 17'h00040,
    ST_MERGE2   = 17'h00080,
    ST_DROP_P   = 17'h00100,
    ST_DROP_PW  = 17'h00200,
    ST_DROP_N   = 17'h00400,
    ST_DROP_NW  = 17'h00800,
    ST_DROP_END = 17'h01000,
    ST_PUSH     = 17'h02000,
    ST_PUSH_HW  = 17'h04000,
    ST_PUSH_W   = 17'h08000,
    ST_SPLIT    = 17'h10000
  } state_t;

  state_t state;

  page_word_t mem [POOL_DEPTH];
  page_word_t mem_q;
  page_word_t mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;

  logic [10:0]       reg_pool;
  logic [OL-1:0]     reg_base;
  logic [LINK_W-1:0] act_pages;
  logic [OL-1:0]     act_base;

  logic [LINK_W-1:0] heads  [ORDER_LEVELS];
  logic [LINK_W-1:0] counts [ORDER_LEVELS];
  logic [LINK_W-1:0] free_total;
  logic [LINK_W-1:0] cnt;

  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  b;
  logic [IDX_W-1:0]  pi;
  logic [OW-1:0]     o;
  logic [OW-1:0]     k;
  logic [OW-1:0]     po;
  logic [OW-1:0]     req_r;
  logic [LINK_W-1:0] p;
  logic [LINK_W-1:0] n;
  logic [LINK_W-1:0] nxt;
  logic              init_run;
  logic              drop_to_merge;
  logic              push_to_split;
  logic [1:0]        status_r;
  logic [IDX_W-1:0]  blk_r;

  logic [OW-1:0]     found;
  logic              any;
  logic [OW-1:0]     lvl;
  logic [OL-1:0]     fsum;
  logic [BW-1:0]     step;
  logic [BW-1:0]     bsum;
  logic              up;
  logic              bvalid;
  logic [IDX_W-1:0]  bud;
  logic [IDX_W-1:0]  ni;

  assign busy = (state != ST_IDLE);
  assign result.status      = status_r;
  assign result.block_index = 10'(blk_r);
  assign result.free_pages  = 11'(free_total);

  always_comb begin
    any   = 1'b0;
    found = '0;
    for (int l = OL - 1; l >= 0; l--) begin
      if (l >= int'(request.order) && counts[l] != '0) begin
        any   = 1'b1;
        found = OW'(l);
      end
    end
  end

  // Buddy of page i: bit lvl of the absolute frame picks the direction.
  always_comb begin
    lvl    = (state == ST_SPLIT) ? OW'(k - 1'b1) : o;
    fsum   = act_base + OL'(i);
    up     = !fsum[lvl];
    step   = BW'(1) << lvl;
    bsum   = up ? (BW'(i) + step) : (BW'(i) - step);
    bvalid = (up || BW'(i) >= step) && (bsum < BW'(act_pages));
    bud    = IDX_W'(bsum);
    ni     = (b < i) ? b : i;
  end

  always_comb begin
    mem_raddr = i;
    mem_waddr = i;
    mem_we    = 1'b0;
    mem_wdata = mem_q;
    unique case (state)
      ST_IDLE: begin
        if (request.mode == bpa_pkg::MODE_FREE) begin
          mem_raddr = IDX_W'(request.page_index);
        end else begin
          mem_raddr = IDX_W'(heads[found]);
        end
      end
      ST_REL:    mem_raddr = bud;
      ST_DROP_P: mem_raddr = IDX_W'(p);
      ST_DROP_N: mem_raddr = IDX_W'(n);
      ST_PUSH:   mem_raddr = IDX_W'(heads[po]);
      ST_DROP_PW: begin
        mem_we         = 1'b1;
        mem_waddr      = IDX_W'(p);
        mem_wdata.next = n;
      end
      ST_DROP_NW: begin
        mem_we         = 1'b1;
        mem_waddr      = IDX_W'(n);
        mem_wdata.prev = p;
      end
      ST_PUSH_HW: begin
        mem_we         = 1'b1;
        mem_waddr      = IDX_W'(nxt);
        mem_wdata.prev = LINK_W'(pi);
      end
      ST_PUSH_W: begin
        mem_we    = 1'b1;
        mem_waddr = pi;
        mem_wdata = '{taken: 1'b0, order: po, next: nxt, prev: NIL};
      end
      ST_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = ni;
        mem_wdata = '{taken: 1'b0, order: OW'(o + 1'b1), next: '0, prev: '0};
      end
      ST_MERGE2: begin
        mem_we    = bvalid;
        mem_waddr = bud;
        mem_wdata = '{taken: 1'b0, order: OW'(o + 1'b1), next: '0, prev: '0};
      end
      ST_SPLIT: begin
        mem_we    = (k == req_r);
        mem_waddr = i;
        mem_wdata = '{taken: 1'b1, order: req_r, next: '0, prev: '0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      init_run   <= 1'b0;
      act_pages  <= '0;
      act_base   <= '0;
      free_total <= '0;
      cnt        <= '0;
      reg_pool   <= bpa_pkg::POOL_PAGES_RESET;
      reg_base   <= '0;
      for (int l = 0; l < OL; l++) begin
        heads[l]  <= NIL;
        counts[l] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          bpa_pkg::REG_POOL_PAGES: reg_pool <= 11'(cfg_data);
          bpa_pkg::REG_BASE_FRAME: reg_base <= OL'(cfg_data);
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            status_r <= bpa_pkg::STATUS_OK;
            blk_r    <= '0;
            init_run <= 1'b0;
            unique case (request.mode)
              bpa_pkg::MODE_INIT: begin
                act_pages  <= (32'(reg_pool) > POOL_DEPTH) ? NIL : LINK_W'(reg_pool);
                act_base   <= reg_base;
                free_total <= '0;
                cnt        <= '0;
                init_run   <= 1'b1;
                for (int l = 0; l < OL; l++) begin
                  heads[l]  <= NIL;
                  counts[l] <= '0;
                end
                state <= ST_INIT;
              end
              bpa_pkg::MODE_ALLOC: begin
                req_r <= OW'(request.order);
                o     <= found;
                i     <= IDX_W'(heads[found]);
                if (int'(request.order) < OL && any && 32'(heads[found]) < POOL_DEPTH) begin
                  state <= ST_A_RD;
                end else begin
                  status_r <= bpa_pkg::STATUS_NO_BLK;
                  done     <= 1'b1;
                end
              end
              bpa_pkg::MODE_FREE: begin
                i <= IDX_W'(request.page_index);
                if (32'(request.page_index) < 32'(act_pages)) begin
                  state <= ST_F_CHK;
                end else begin
                  status_r <= bpa_pkg::STATUS_BAD_FREE;
                  done     <= 1'b1;
                end
              end
              default: begin
                status_r <= bpa_pkg::STATUS_NO_BLK;
                done     <= 1'b1;
              end
            endcase
          end
        end
        ST_INIT: begin
          if (cnt < act_pages) begin
            i     <= IDX_W'(cnt);
            o     <= '0;
            state <= ST_REL;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_F_CHK: begin
          if (mem_q.taken) begin
            o     <= mem_q.order;
            state <= ST_REL;
          end else begin
            status_r <= bpa_pkg::STATUS_BAD_FREE;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_A_RD: begin
          p             <= mem_q.prev;
          n             <= mem_q.next;
          k             <= o;
          drop_to_merge <= 1'b0;
          state         <= ST_DROP_P;
        end
        ST_REL: begin
          pi            <= i;
          po            <= o;
          push_to_split <= 1'b0;
          b             <= bud;
          // During init, pages above the current one are still taken.
          if (32'(o) + 1 >= OL || !bvalid || (init_run && bud > i)) begin
            state <= ST_PUSH;
          end else begin
            state <= ST_REL_BUD;
          end
        end
        ST_REL_BUD: begin
          if (!mem_q.taken && mem_q.order == o) begin
            p             <= mem_q.prev;
            n             <= mem_q.next;
            drop_to_merge <= 1'b1;
            state         <= ST_DROP_P;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_DROP_P: begin
          if (32'(p) < POOL_DEPTH) begin
            state <= ST_DROP_PW;
          end else begin
            heads[o] <= n;
            state    <= ST_DROP_N;
          end
        end
        ST_DROP_PW: state <= ST_DROP_N;
        ST_DROP_N: begin
          state <= (32'(n) < POOL_DEPTH) ? ST_DROP_NW : ST_DROP_END;
        end
        ST_DROP_NW: state <= ST_DROP_END;
        ST_DROP_END: begin
          if (counts[o] != '0) begin
            counts[o]  <= counts[o] - 1'b1;
            free_total <= free_total - (LINK_W'(1) << o);
          end
          if (counts[o] == '0 || counts[o] == LINK_W'(1)) begin
            heads[o] <= NIL;
          end
          state <= drop_to_merge ? ST_MERGE : ST_SPLIT;
        end
        ST_MERGE: begin
          i     <= ni;
          state <= ST_MERGE2;
        end
        ST_MERGE2: begin
          o     <= OW'(o + 1'b1);
          state <= ST_REL;
        end
        ST_PUSH: begin
          if (counts[po] != '0 && 32'(heads[po]) < POOL_DEPTH) begin
            nxt   <= heads[po];
            state <= ST_PUSH_HW;
          end else begin
            nxt   <= NIL;
            state <= ST_PUSH_W;
          end
        end
        ST_PUSH_HW: state <= ST_PUSH_W;
        ST_PUSH_W: begin
          heads[po]  <= LINK_W'(pi);
          counts[po] <= counts[po] + 1'b1;
          free_total <= free_total + (LINK_W'(1) << po);
          if (push_to_split) begin
            state <= ST_SPLIT;
          end else if (init_run) begin
            cnt   <= cnt + 1'b1;
            state <= ST_INIT;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_SPLIT: begin
          if (k > req_r) begin
            k <= OW'(k - 1'b1);
            if (bvalid) begin
              pi            <= bud;
              po            <= OW'(k - 1'b1);
              push_to_split <= 1'b1;
              state         <= ST_PUSH;
            end
          end else begin
            blk_r <= i;
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BPA_ASSERT_NEXT(a_accept_progress, clk, rst, (start && !busy), (busy || done), "request lost")
  `BPA_ASSERT(a_free_bound, clk, rst, (done |-> 32'(free_total) <= 32'(act_pages)), "free count exceeds pool")
  `BPA_ASSERT(a_split_floor, clk, rst, ((state == ST_SPLIT) |-> k >= req_r), "split below requested order")

endmodule
`default_nettype wire

>>> verif/buddy_page_allocator_test.sv
// Self-checking testbench for the buddy page allocator with its own allocator model.
`default_nettype none
module buddy_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = 1024;
  localparam int LEVELS = 11;
  localparam logic [10:0] NIL = 11'd1024;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bpa_pkg::request_t request = '0;
  logic done;
  bpa_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  buddy_page_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Allocator model state.
  logic [3:0]  pg_order [DEPTH];
  logic        pg_taken [DEPTH];
  logic [10:0] pg_next [DEPTH];
  logic [10:0] pg_prev [DEPTH];
  logic [10:0] lst_head [LEVELS];
  logic [10:0] lst_count [LEVELS];
  logic [10:0] cfg_pages = bpa_pkg::POOL_PAGES_RESET;
  logic [35:0] cfg_base = '0;
  int unsigned pool_size = 0;
  logic [63:0] pool_base = '0;
  int live_heads[$];

  bpa_pkg::result_t expected_results[$];
  int fail_count = 0;
  int idle_pct = 0;

  function automatic void list_push(int o, int i);
    if (lst_count[o] > 0 && lst_head[o] < NIL) begin
      pg_next[i] = lst_head[o];
      pg_prev[lst_head[o]] = 11'(i);
    end else begin
      pg_next[i] = NIL;
    end
    pg_prev[i] = NIL;
    lst_head[o] = 11'(i);
    lst_count[o]++;
  endfunction

  function automatic void list_drop(int o, int i);
    logic [10:0] p, n;
    p = pg_prev[i];
    n = pg_next[i];
    if (p < NIL) pg_next[p] = n;
    else lst_head[o] = n;
    if (n < NIL) pg_prev[n] = p;
    if (lst_count[o] > 0) lst_count[o]--;
    if (lst_count[o] == 0) lst_head[o] = NIL;
  endfunction

  function automatic int buddy_index(int i, int o);
    logic [63:0] bi;
    bi = ((pool_base + 64'(i)) ^ (64'd1 << o)) - pool_base;
    if (bi >= 64'(pool_size)) return -1;
    return int'(bi);
  endfunction

  function automatic void return_block(int i);
    int b, o;
    pg_taken[i] = 1'b0;
    forever begin
      o = pg_order[i];
      if (o + 1 >= LEVELS) break;
      b = buddy_index(i, o);
      if (b < 0) break;
      if (pg_taken[b] || pg_order[b] != o) break;
      list_drop(o, b);
      if (b < i) i = b;
      pg_order[i] = 4'(o + 1);
      b = buddy_index(i, o);
      if (b >= 0) pg_order[b] = 4'(o + 1);
    end
    list_push(pg_order[i], i);
  endfunction

  function automatic bpa_pkg::result_t predict_request(bpa_pkg::request_t r);
    bpa_pkg::result_t res;
    int o, k, i, b;
    logic [10:0] total;
    res = '0;
    case (r.mode)
      bpa_pkg::MODE_INIT: begin
        pool_size = (cfg_pages > DEPTH) ? DEPTH : cfg_pages;
        pool_base = 64'(cfg_base);
        live_heads.delete();
        for (o = 0; o < LEVELS; o++) begin
          lst_head[o] = NIL;
          lst_count[o] = '0;
        end
        for (i = 0; i < DEPTH; i++) begin
          pg_taken[i] = (i < pool_size);
          pg_order[i] = '0;
        end
        for (i = 0; i < pool_size; i++) return_block(i);
      end
      bpa_pkg::MODE_ALLOC: begin
        res.status = bpa_pkg::STATUS_NO_BLK;
        if (r.order < LEVELS) begin
          for (o = r.order; o < LEVELS; o++)
            if (lst_count[o] > 0) break;
          if (o < LEVELS && lst_head[o] < NIL) begin
            i = lst_head[o];
            list_drop(o, i);
            for (k = o; k > r.order; k--) begin
              pg_order[i] = 4'(k - 1);
              b = buddy_index(i, k - 1);
              if (b >= 0) begin
                pg_order[b] = 4'(k - 1);
                pg_taken[b] = 1'b0;
                list_push(k - 1, b);
              end
            end
            pg_order[i] = r.order;
            pg_taken[i] = 1'b1;
            res.status = bpa_pkg::STATUS_OK;
            res.block_index = 10'(i);
            live_heads.push_back(i);
          end
        end
      end
      bpa_pkg::MODE_FREE: begin
        i = r.page_index;
        if (i < pool_size && pg_taken[i]) begin
          return_block(i);
          foreach (live_heads[h])
            if (live_heads[h] == i) begin
              live_heads.delete(h);
              break;
            end
        end else begin
          res.status = bpa_pkg::STATUS_BAD_FREE;
        end
      end
      default: res.status = bpa_pkg::STATUS_NO_BLK;
    endcase
    total = '0;
    for (o = 0; o < LEVELS; o++) total += lst_count[o] << o;
    res.free_pages = total;
    return res;
  endfunction

  always @(posedge clk) begin
    bpa_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result: status %0d block %0d free %0d",
                   result.status, result.block_index, result.free_pages);
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status || result.block_index !== want.block_index ||
            result.free_pages !== want.free_pages) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: expected status %0d block %0d free %0d, got %0d %0d %0d",
                     want.status, want.block_index, want.free_pages,
                     result.status, result.block_index, result.free_pages);
        end
      end
    end
  end

  task automatic send_request(logic [1:0] mode, logic [3:0] order, logic [9:0] idx);
    bpa_pkg::request_t r;
    r.mode = mode;
    r.order = order;
    r.page_index = idx;
    request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_request(r));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bpa_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpa_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bpa_pkg::REG_POOL_PAGES) cfg_pages = data[10:0];
    else cfg_base = data;
  endtask

  task automatic test_before_init();
    send_request(bpa_pkg::MODE_ALLOC, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd0);
    send_request(MODE_UNUSED, 4'd15, 10'd1023);
  endtask

  task automatic test_full_pool();
    write_reg(bpa_pkg::REG_POOL_PAGES, 36'd1024);
    write_reg(bpa_pkg::REG_BASE_FRAME, 36'd0);
    send_request(bpa_pkg::MODE_INIT, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd10, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd1);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd15, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd11, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd1);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd0);
  endtask

  task automatic test_pool_edges();
    write_reg(bpa_pkg::REG_POOL_PAGES, 36'd0);
    send_request(bpa_pkg::MODE_INIT, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd0, 10'd0);
    write_reg(bpa_pkg::REG_POOL_PAGES, 36'h7FF);
    write_reg(bpa_pkg::REG_BASE_FRAME, 36'hF_FFFF_FFFF);
    send_request(bpa_pkg::MODE_INIT, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd3, 10'd0);
    write_reg(bpa_pkg::REG_POOL_PAGES, 36'd1);
    write_reg(bpa_pkg::REG_BASE_FRAME, 36'd5);
    send_request(bpa_pkg::MODE_INIT, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_ALLOC, 4'd0, 10'd0);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd1023);
    send_request(bpa_pkg::MODE_FREE, 4'd0, 10'd0);
  endtask

  task automatic run_random(int items);
    int n, pick;
    logic [35:0] data;
    n = 0;
    while (n < items) begin
      pick = $urandom_range(9);
      data = 36'({$urandom, $urandom});
      if (pick == 0) data[10:0] = 11'($urandom_range(1, 2047));
      else data[10:0] = 11'($urandom_range(1, 80));
      write_reg(bpa_pkg::REG_POOL_PAGES, data);
      data = 36'({$urandom, $urandom});
      if ($urandom_range(2) != 0) data = 36'($urandom_range(0, 40));
      write_reg(bpa_pkg::REG_BASE_FRAME, data);
      send_request(bpa_pkg::MODE_INIT, 4'($urandom), 10'($urandom));
      repeat (60) begin
        pick = $urandom_range(99);
        if (pick < 45)
          send_request(bpa_pkg::MODE_ALLOC, 4'($urandom_range(0, 3)), 10'($urandom));
        else if (pick < 85 && live_heads.size() > 0)
          send_request(bpa_pkg::MODE_FREE, 4'($urandom),
                       10'(live_heads[$urandom_range(0, live_heads.size() - 1)]));
        else if (pick < 93)
          send_request(bpa_pkg::MODE_FREE, 4'($urandom), 10'($urandom));
        else if (pick < 96)
          send_request(MODE_UNUSED, 4'($urandom), 10'($urandom));
        else
          send_request(bpa_pkg::MODE_ALLOC, 4'($urandom), 10'($urandom));
      end
      n += 61;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 20;
    test_before_init();
    test_full_pool();
    test_pool_edges();
    run_random(610);
    idle_pct = 52;
    run_random(610);
    idle_pct = 0;
    run_random(610);
    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
